/* src/chs_pkg.sv */
// Shared types and constants for the chained hash set unit.
// No dependencies; imported by the modulo unit, the top level and the checker.
`default_nettype none

package chs_pkg;

  localparam int KEY_W     = 31;
  localparam int CMD_W     = 2;
  localparam int CNT_W     = 5;
  localparam int BKT_OUT_W = 4;
  localparam int CNT_MAX   = (1 << CNT_W) - 1;

  localparam logic [CNT_W-1:0] CNT_RESET = 5'd7;

  // Modulo unit: key bits retired per cycle, and the step count and widths derived from it.
  localparam int MOD_STEPS  = 4;
  localparam int MOD_CYCLES = (KEY_W + MOD_STEPS - 1) / MOD_STEPS;
  localparam int MOD_PAD_W  = MOD_CYCLES * MOD_STEPS;
  localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

endpackage

`default_nettype wire

/* src/chs_mod_unit.sv */
// Key modulo bucket count: restoring remainder, MOD_STEPS key bits per cycle.
// Depends on chs_pkg for key and count widths.
`default_nettype none

module chs_mod_unit import chs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic      [CNT_W-1:0] rem
);

  logic                 run_r;
  logic                 done_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic [MOD_PAD_W-1:0] sr_r;
  logic [CNT_W-1:0]     div_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     rem_nxt;

  // Shift in MOD_STEPS key bits one at a time, subtracting the divisor where it fits.
  always_comb begin
    logic [CNT_W:0]   t;
    logic [CNT_W-1:0] r;
    r = rem_r;
    for (int j = 0; j < MOD_STEPS; j++) begin
      t = {r, sr_r[MOD_PAD_W-1-j]};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      r = t[CNT_W-1:0];
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        sr_r  <= MOD_PAD_W'(dividend);
        div_r <= divisor;
        rem_r <= '0;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        sr_r  <= sr_r << MOD_STEPS;
        cnt_r <= cnt_r + MOD_CNT_W'(1);
        if (cnt_r == MOD_CNT_W'(MOD_CYCLES - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

/* src/chs_entry_ram.sv */
// Bucket entry store: one write port, one read port, registered read data.
// No package dependencies.
`default_nettype none

module chs_entry_ram #(
  parameter int ADDR_W = 7,
  parameter int DATA_W = 31
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/chained_hash_set_unit.sv */
// Chained hash set of 31-bit keys: top level with command sequencer and fill counts.
// Depends on chs_pkg, chs_mod_unit and chs_entry_ram.
//
// Usage:
//   Input: present in_command / in_key with start; the request is taken at an
//   edge where start is high and busy is low. Commands: insert, delete, search.
//   Output: one result per request, shown for a single cycle with out_valid:
//   out_hit, out_overflow and out_bucket (key modulo the bucket count).
//   The receiver cannot stall; the result must be taken in that cycle.
//   Config: cfg_bucket_count is written when cfg_valid and cfg_ready are high;
//   cfg_ready is low while a request is in flight. Change it only when empty.
// Timing:
//   A request passes the modulo unit (S_MOD), then the bucket state S_BKT,
//   which gives the result for insert, unused commands and an empty bucket.
//   Delete and search walk the bucket one entry per cycle through the entry
//   memory read port in S_SCAN; a delete that does not hit the last entry
//   adds the slot move in S_MOVE.
//   busy falls with out_valid, so the next request can be taken at the edge
//   that ends the result cycle.
// Reset:
//   rst_n (synchronous) empties every bucket and sets the bucket count to 7.
//   The entry memory needs no clearing: only slots below a fill count are read.
`default_nettype none

module chained_hash_set_unit import chs_pkg::*; #(
  parameter int NUM_BUCKETS  = 16,
  parameter int BUCKET_DEPTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CMD_W-1:0]     in_command,
  input  wire logic [KEY_W-1:0]     in_key,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic                      out_overflow,
  output logic      [BKT_OUT_W-1:0] out_bucket,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CNT_W-1:0]     cfg_bucket_count
);

  // The count register cannot exceed CNT_MAX, so no more buckets are ever used.
  localparam int USED_BKTS = (NUM_BUCKETS < CNT_MAX) ? NUM_BUCKETS : CNT_MAX;
  localparam int BKT_W     = (USED_BKTS > 1) ? $clog2(USED_BKTS) : 1;
  localparam int SLOT_W    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FILL_W    = $clog2(BUCKET_DEPTH + 1);
  localparam int ADDR_W    = BKT_W + SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_BKT,
    S_SCAN,
    S_MOVE
  } state_t;

  state_t                state_r;
  cmd_t                  cmd_r;
  logic [KEY_W-1:0]      key_r;
  logic [BKT_W-1:0]      bkt_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [CNT_W-1:0]      bucket_count_r;
  logic [FILL_W-1:0]     fill_r [USED_BKTS];
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic                  out_overflow_r;
  logic [BKT_OUT_W-1:0]  out_bucket_r;

  logic [CNT_W-1:0]  count_eff;
  logic              mod_start;
  logic              mod_done;
  logic [CNT_W-1:0]  mod_rem;
  logic [FILL_W-1:0] fill_cur;
  logic [FILL_W-1:0] fill_last;
  logic [SLOT_W-1:0] last_slot;
  logic [FILL_W-1:0] slot_succ;
  logic              more;
  logic              match;
  logic              bucket_full;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;

  // Zero counts as one bucket; anything above the table size is clamped.
  always_comb begin
    if (bucket_count_r == '0) begin
      count_eff = CNT_W'(1);
    end else if (int'(bucket_count_r) > USED_BKTS) begin
      count_eff = CNT_W'(USED_BKTS);
    end else begin
      count_eff = bucket_count_r;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign mod_start = start && !busy;

  chs_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_key),
    .divisor  (count_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  chs_entry_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign fill_cur    = fill_r[bkt_r];
  assign fill_last   = fill_cur - FILL_W'(1);
  assign last_slot   = SLOT_W'(fill_last);
  assign slot_succ   = FILL_W'(slot_r) + FILL_W'(1);
  assign more        = (slot_succ < fill_cur);
  assign match       = (ram_rdata == key_r);
  assign bucket_full = (fill_cur >= FILL_W'(BUCKET_DEPTH));

  // Entry memory requests: append on insert, walk on scan, fill the hole on move.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {bkt_r, SLOT_W'(fill_cur)};
    ram_wdata = key_r;
    ram_re    = 1'b0;
    ram_raddr = {bkt_r, SLOT_W'(0)};
    case (state_r)
      S_BKT: begin
        if (cmd_r == CMD_INSERT) begin
          ram_we = !bucket_full;
        end else if (cmd_r == CMD_DELETE || cmd_r == CMD_SEARCH) begin
          ram_re = (fill_cur != '0);
        end
      end
      S_SCAN: begin
        if (match) begin
          ram_re    = (cmd_r == CMD_DELETE) && (slot_r != last_slot);
          ram_raddr = {bkt_r, last_slot};
        end else begin
          ram_re    = more;
          ram_raddr = {bkt_r, SLOT_W'(slot_succ)};
        end
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = {bkt_r, slot_r};
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      bucket_count_r <= CNT_RESET;
      for (int i = 0; i < USED_BKTS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        bucket_count_r <= cfg_bucket_count;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= cmd_t'(in_command);
            key_r   <= in_key;
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            bkt_r        <= BKT_W'(mod_rem);
            out_bucket_r <= mod_rem[BKT_OUT_W-1:0];
            state_r      <= S_BKT;
          end
        end
        S_BKT: begin
          slot_r         <= '0;
          out_hit_r      <= 1'b0;
          out_overflow_r <= 1'b0;
          case (cmd_r)
            CMD_INSERT: begin
              if (bucket_full) begin
                out_overflow_r <= 1'b1;
              end else begin
                fill_r[bkt_r] <= fill_cur + FILL_W'(1);
              end
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
            CMD_DELETE, CMD_SEARCH: begin
              if (fill_cur == '0) begin
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else begin
                state_r <= S_SCAN;
              end
            end
            default: begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          endcase
        end
        S_SCAN: begin
          if (match) begin
            if (cmd_r == CMD_SEARCH) begin
              out_hit_r   <= 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else if (slot_r == last_slot) begin
              // Last entry removed: nothing to move.
              fill_r[bkt_r] <= fill_last;
              out_hit_r     <= 1'b1;
              out_valid_r   <= 1'b1;
              state_r       <= S_IDLE;
            end else begin
              state_r <= S_MOVE;
            end
          end else if (more) begin
            slot_r <= slot_r + SLOT_W'(1);
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_MOVE: begin
          fill_r[bkt_r] <= fill_last;
          out_hit_r     <= 1'b1;
          out_valid_r   <= 1'b1;
          state_r       <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_overflow = out_overflow_r;
  assign out_bucket   = out_bucket_r;

endmodule

`default_nettype wire

/* src/chs_checker.sv */
// Port-level checks for the chained hash set unit, bound to the top level.
// Depends on chs_pkg for port widths.
`default_nettype none

module chs_checker import chs_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire logic                 out_hit,
  input wire logic                 out_overflow,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready
);

  // A taken request keeps the unit busy until its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but unit not busy");

  // The result cycle finds the unit back in idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && cfg_ready))
    else $error("result shown while busy");

  // One request gives one strobe, never two in a row.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // No result in the cycle after a request is taken: the modulo unit runs first.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result too early after request");

  // A refused insert never reports a hit.
  a_ovf_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> !out_hit)
    else $error("overflow and hit together");

endmodule

bind chained_hash_set_unit chs_checker u_chs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_hit      (out_hit),
  .out_overflow (out_overflow),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire
